/* rtl/core/thinning_subpass_3x3_assert.svh */
// ----------------------------------------------------------------------------
// thinning_subpass_3x3 assertion macros
// Shared concurrent assertion forms for the thinning sub-pass block.
// ----------------------------------------------------------------------------
`ifndef THINNING_SUBPASS_3X3_ASSERT_SVH
`define THINNING_SUBPASS_3X3_ASSERT_SVH

// same-cycle implication, held off during reset
`define TSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thinning_subpass_3x3: same-cycle check failed");

// next-cycle implication, held off during reset
`define TSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thinning_subpass_3x3: next-cycle check failed");

`endif

/* rtl/core/tsp_pkg.sv */
// ----------------------------------------------------------------------------
// tsp_pkg
// Types, constants and the thinning decision shared by the sub-pass modules.
// ----------------------------------------------------------------------------
package tsp_pkg;

    // widest row the line stores hold
    localparam int MAX_WIDTH = 1024;

    localparam int COL_W  = $clog2(MAX_WIDTH);      // column index / store address
    localparam int UW_W   = $clog2(MAX_WIDTH + 1);  // used width, holds MAX_WIDTH
    localparam int PEND_W = $clog2(MAX_WIDTH + 2);  // drain count, holds width + 1

    localparam int PIX_W       = 8;
    localparam int ROW_W       = 16;
    localparam int WIDTH_FLD_W = 11;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;

    localparam int MIN_DIM      = 3;
    localparam int RESET_WIDTH  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int RESET_HEIGHT = 480;

    localparam logic [PIX_W-1:0] FG_VALUE = 8'd255;
    localparam logic [3:0]       MIN_NB   = 4'd2;
    localparam logic [3:0]       MAX_NB   = 4'd6;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH    = 2'd0,
        CFG_HEIGHT   = 2'd1,
        CFG_SUB_PASS = 2'd2
    } t_cfg_idx;

    // per-beat control decided at accept time
    typedef struct packed {
        logic             is_flush;
        logic             produce;
        logic             thin_en;
        logic             last;
        logic             from_mem;
        logic [COL_W-1:0] addr;
    } t_item_ctl;

    function automatic logic is_fg(input logic [PIX_W-1:0] v);
        return v == FG_VALUE;
    endfunction

    // nb[0..7] = P2..P9 around the ring
    function automatic logic thin_delete(input logic [7:0] nb, input logic sel);
        logic [3:0] cnt;
        logic [3:0] steps;
        logic       a;
        logic       b;
        cnt   = '0;
        steps = '0;
        for (int i = 0; i < 8; i++) begin
            cnt = cnt + {3'b000, nb[i]};
            if (!nb[i] && nb[(i + 1) % 8]) begin
                steps = steps + 4'd1;
            end
        end
        if (!sel) begin
            a = nb[0] & nb[2] & nb[4];
            b = nb[2] & nb[4] & nb[6];
        end else begin
            a = nb[0] & nb[2] & nb[6];
            b = nb[0] & nb[4] & nb[6];
        end
        return (cnt >= MIN_NB) && (cnt <= MAX_NB) && (steps == 4'd1) && !a && !b;
    endfunction

endpackage

/* rtl/core/tsp_ctrl.sv */
// ----------------------------------------------------------------------------
// tsp_ctrl
// Configuration registers, raster position and drain count; decides what
// each accepted beat does and where it reads the line stores.
// ----------------------------------------------------------------------------
module tsp_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tsp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tsp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_accept,
    input  logic                              i_command,
    output tsp_pkg::t_item_ctl                o_ctl,
    output logic                              o_sel
);

    logic [tsp_pkg::UW_W-1:0]   r_width;
    logic [tsp_pkg::ROW_W-1:0]  r_height;
    logic                       r_sel;
    logic [tsp_pkg::COL_W-1:0]  r_col;
    logic [tsp_pkg::ROW_W-1:0]  r_row;
    logic [tsp_pkg::PEND_W-1:0] r_pend;

    logic                           restart_px;
    logic [tsp_pkg::COL_W-1:0]      col_e;
    logic [tsp_pkg::ROW_W-1:0]      row_e;
    logic [tsp_pkg::UW_W-1:0]       col_nx;
    logic                           wrap;
    logic [tsp_pkg::ROW_W:0]        row_nx;
    logic                           last_row;
    logic [tsp_pkg::PEND_W-1:0]     pend_full;
    logic [tsp_pkg::PEND_W-1:0]     fl_addr;
    logic [tsp_pkg::WIDTH_FLD_W-1:0] wv;
    logic [tsp_pkg::UW_W-1:0]       w_clamped;
    logic [tsp_pkg::ROW_W-1:0]      h_clamped;
    logic                           cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign o_sel       = r_sel;

    always_comb begin
        wv = i_cfg_data[tsp_pkg::WIDTH_FLD_W-1:0];
        if (wv < tsp_pkg::WIDTH_FLD_W'(tsp_pkg::MIN_DIM)) begin
            w_clamped = tsp_pkg::UW_W'(tsp_pkg::MIN_DIM);
        end else if (32'(wv) > tsp_pkg::MAX_WIDTH) begin
            w_clamped = tsp_pkg::UW_W'(tsp_pkg::MAX_WIDTH);
        end else begin
            w_clamped = tsp_pkg::UW_W'(wv);
        end
        if (i_cfg_data[tsp_pkg::ROW_W-1:0] < tsp_pkg::ROW_W'(tsp_pkg::MIN_DIM)) begin
            h_clamped = tsp_pkg::ROW_W'(tsp_pkg::MIN_DIM);
        end else begin
            h_clamped = i_cfg_data[tsp_pkg::ROW_W-1:0];
        end
    end

    always_comb begin
        // a pixel after the frame ended starts a new frame
        restart_px = (r_row >= r_height);
        col_e      = restart_px ? '0 : r_col;
        row_e      = restart_px ? '0 : r_row;
        col_nx     = tsp_pkg::UW_W'(col_e) + tsp_pkg::UW_W'(1);
        wrap       = (col_nx >= r_width);
        row_nx     = {1'b0, row_e} + (tsp_pkg::ROW_W + 1)'(1);
        last_row   = (row_nx >= {1'b0, r_height});
        pend_full  = tsp_pkg::PEND_W'(r_width) + tsp_pkg::PEND_W'(1);
        fl_addr    = tsp_pkg::PEND_W'(r_width) - r_pend;

        o_ctl = '0;
        if (i_command == tsp_pkg::CMD_FLUSH) begin
            o_ctl.is_flush = 1'b1;
            o_ctl.produce  = (r_pend != '0);
            o_ctl.last     = (r_pend == tsp_pkg::PEND_W'(1));
            // first drained beat is the last column two rows up, held in the window
            o_ctl.from_mem = (r_pend != pend_full);
            o_ctl.addr     = fl_addr[tsp_pkg::COL_W-1:0];
        end else begin
            if (col_e == '0) begin
                o_ctl.produce = (row_e >= tsp_pkg::ROW_W'(2));
            end else begin
                o_ctl.produce = (row_e >= tsp_pkg::ROW_W'(1));
            end
            o_ctl.thin_en = (row_e >= tsp_pkg::ROW_W'(2)) && (col_e >= tsp_pkg::COL_W'(2));
            o_ctl.addr    = col_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= tsp_pkg::UW_W'(tsp_pkg::RESET_WIDTH);
            r_height <= tsp_pkg::ROW_W'(tsp_pkg::RESET_HEIGHT);
            r_sel    <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_pend   <= '0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                tsp_pkg::CFG_WIDTH: begin
                    r_width <= w_clamped;
                    r_col   <= '0;
                    r_row   <= '0;
                    r_pend  <= '0;
                end
                tsp_pkg::CFG_HEIGHT: begin
                    r_height <= h_clamped;
                    r_col    <= '0;
                    r_row    <= '0;
                    r_pend   <= '0;
                end
                tsp_pkg::CFG_SUB_PASS: begin
                    r_sel <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            if (i_command == tsp_pkg::CMD_FLUSH) begin
                if (r_pend != '0) begin
                    r_pend <= r_pend - tsp_pkg::PEND_W'(1);
                    if (r_pend == tsp_pkg::PEND_W'(1)) begin
                        r_row <= '0;
                        r_col <= '0;
                    end
                end
            end else begin
                r_col  <= wrap ? '0 : col_nx[tsp_pkg::COL_W-1:0];
                r_row  <= wrap ? row_nx[tsp_pkg::ROW_W-1:0] : row_e;
                r_pend <= (wrap && last_row) ? pend_full : '0;
            end
        end
    end

endmodule

/* rtl/core/tsp_line_buf.sv */
// ----------------------------------------------------------------------------
// tsp_line_buf
// The two row stores: middle holds the previous row, upper the one before.
// Reads are registered and held while the window stage is blocked.
// ----------------------------------------------------------------------------
module tsp_line_buf (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [tsp_pkg::COL_W-1:0]     i_rd_addr,
    input  logic                          i_mid_wr_en,
    input  logic [tsp_pkg::PIX_W-1:0]     i_mid_wr_data,
    input  logic                          i_up_wr_en,
    input  logic [tsp_pkg::COL_W-1:0]     i_up_wr_addr,
    output logic [tsp_pkg::PIX_W-1:0]     o_top,
    output logic [tsp_pkg::PIX_W-1:0]     o_mid
);

    logic [tsp_pkg::PIX_W-1:0] r_upper_mem  [tsp_pkg::MAX_WIDTH];
    logic [tsp_pkg::PIX_W-1:0] r_middle_mem [tsp_pkg::MAX_WIDTH];
    logic [tsp_pkg::PIX_W-1:0] r_top;
    logic [tsp_pkg::PIX_W-1:0] r_mid;

    // upper takes the old middle value of the beat now in the window stage
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_top <= r_upper_mem[i_rd_addr];
        end
        if (i_up_wr_en) begin
            r_upper_mem[i_up_wr_addr] <= r_mid;
        end
    end

    // read before write at the same address
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_mid <= r_middle_mem[i_rd_addr];
        end
        if (i_mid_wr_en) begin
            r_middle_mem[i_rd_addr] <= i_mid_wr_data;
        end
    end

    assign o_top = r_top;
    assign o_mid = r_mid;

endmodule

/* rtl/core/tsp_window.sv */
// ----------------------------------------------------------------------------
// tsp_window
// Window stage and result register: holds the 3x3 neighborhood, makes the
// delete decision and drives the output channel.
// ----------------------------------------------------------------------------
module tsp_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  tsp_pkg::t_item_ctl            i_ctl,
    input  logic [tsp_pkg::PIX_W-1:0]     i_pixel,
    input  logic [tsp_pkg::PIX_W-1:0]     i_top,
    input  logic [tsp_pkg::PIX_W-1:0]     i_mid,
    input  logic                          i_sel,
    input  logic                          i_out_stall,
    output logic                          o_in_stall,
    output logic                          o_up_wr_en,
    output logic [tsp_pkg::COL_W-1:0]     o_up_wr_addr,
    output logic                          o_out_valid,
    output logic [tsp_pkg::PIX_W-1:0]     o_pixel_out,
    output logic                          o_frame_last
);

    logic                      r_a_vld;
    tsp_pkg::t_item_ctl        r_a_ctl;
    logic [tsp_pkg::PIX_W-1:0] r_a_pix;
    logic [tsp_pkg::PIX_W-1:0] r_wc [6];
    logic                      r_o_vld;
    logic [tsp_pkg::PIX_W-1:0] r_o_pix;
    logic                      r_o_last;

    logic                      a_adv;
    logic [7:0]                nb;
    logic                      del;
    logic [tsp_pkg::PIX_W-1:0] res_pix;

    // hold the window stage only when its result cannot enter the output register
    assign a_adv      = r_a_vld && (!r_a_ctl.produce || !r_o_vld || !i_out_stall);
    assign o_in_stall = r_a_vld && !a_adv;

    assign o_up_wr_en   = a_adv && !r_a_ctl.is_flush;
    assign o_up_wr_addr = r_a_ctl.addr;

    always_comb begin
        nb[0] = tsp_pkg::is_fg(r_wc[3]);
        nb[1] = tsp_pkg::is_fg(i_top);
        nb[2] = tsp_pkg::is_fg(i_mid);
        nb[3] = tsp_pkg::is_fg(r_a_pix);
        nb[4] = tsp_pkg::is_fg(r_wc[5]);
        nb[5] = tsp_pkg::is_fg(r_wc[2]);
        nb[6] = tsp_pkg::is_fg(r_wc[1]);
        nb[7] = tsp_pkg::is_fg(r_wc[0]);
        del   = r_a_ctl.thin_en && tsp_pkg::is_fg(r_wc[4]) && tsp_pkg::thin_delete(nb, i_sel);
        if (r_a_ctl.from_mem) begin
            res_pix = i_mid;
        end else if (del) begin
            res_pix = '0;
        end else begin
            res_pix = r_wc[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_accept) begin
            r_a_vld <= 1'b1;
        end else if (a_adv) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_ctl <= i_ctl;
            r_a_pix <= i_pixel;
        end
    end

    // advance the window by one column per pixel beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_wc[k] <= '0;
            end
        end else if (a_adv && !r_a_ctl.is_flush) begin
            r_wc[0] <= r_wc[3];
            r_wc[1] <= r_wc[4];
            r_wc[2] <= r_wc[5];
            r_wc[3] <= i_top;
            r_wc[4] <= i_mid;
            r_wc[5] <= r_a_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (a_adv && r_a_ctl.produce) begin
            r_o_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv && r_a_ctl.produce) begin
            r_o_pix  <= res_pix;
            r_o_last <= r_a_ctl.last;
        end
    end

    assign o_out_valid  = r_o_vld;
    assign o_pixel_out  = r_o_pix;
    assign o_frame_last = r_o_last;

endmodule

/* rtl/core/thinning_subpass_3x3.sv */
// ----------------------------------------------------------------------------
// thinning_subpass_3x3
// One thinning sub-pass over a raster stream, 3x3 window over two row stores.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with i_command and i_pixel_in. A
// pixel beat carries the next pixel in raster order; a flush beat drains one
// pending pixel after the frame's last pixel and is ignored otherwise.
// Output channel: o_out_valid / i_out_stall with o_pixel_out and o_frame_last,
// the latter high on the frame's final pixel. Results trail the pixel stream
// by one row plus one pixel; the tail (row width + 1 beats) comes out on
// flush beats.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), index 0 width,
// 1 height, 2 sub-pass select. Width and height writes restart the frame.
// Pipeline: the row store reads and input register take a beat when it is
// accepted; the window logic then moves its result into the result register
// unless the output stalls. Throughput: one beat per clock unless the output
// stalls, set by the single registered read per row store per clock.
// Reset clears the position counters and the window; the row stores need no
// clearing pass. When the receiver stalls, the output register holds and
// o_in_stall rises once the window stage holds a beat that gives a result.
// ----------------------------------------------------------------------------
`include "thinning_subpass_3x3_assert.svh"

module thinning_subpass_3x3 (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_command,
    input  logic [tsp_pkg::PIX_W-1:0]      i_pixel_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [tsp_pkg::PIX_W-1:0]      o_pixel_out,
    output logic                           o_frame_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tsp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tsp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic                      in_accept;
    tsp_pkg::t_item_ctl        ctl;
    logic                      sel;
    logic [tsp_pkg::PIX_W-1:0] top;
    logic [tsp_pkg::PIX_W-1:0] mid;
    logic                      up_wr_en;
    logic [tsp_pkg::COL_W-1:0] up_wr_addr;
    logic                      mid_wr_en;

    assign in_accept = i_in_valid && !o_in_stall;
    assign mid_wr_en = in_accept && (i_command == tsp_pkg::CMD_PIXEL);

    tsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_command   (i_command),
        .o_ctl       (ctl),
        .o_sel       (sel)
    );

    tsp_line_buf u_line_buf (
        .i_clk         (i_clk),
        .i_rd_en       (in_accept),
        .i_rd_addr     (ctl.addr),
        .i_mid_wr_en   (mid_wr_en),
        .i_mid_wr_data (i_pixel_in),
        .i_up_wr_en    (up_wr_en),
        .i_up_wr_addr  (up_wr_addr),
        .o_top         (top),
        .o_mid         (mid)
    );

    tsp_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_ctl        (ctl),
        .i_pixel      (i_pixel_in),
        .i_top        (top),
        .i_mid        (mid),
        .i_sel        (sel),
        .i_out_stall  (i_out_stall),
        .o_in_stall   (o_in_stall),
        .o_up_wr_en   (up_wr_en),
        .o_up_wr_addr (up_wr_addr),
        .o_out_valid  (o_out_valid),
        .o_pixel_out  (o_pixel_out),
        .o_frame_last (o_frame_last)
    );

    // input backs up only behind a blocked result
    `TSP_ASSERT_NOW(a_stall_only_when_blocked, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    // a frame's final beat cannot be followed at once by another
    `TSP_ASSERT_NEXT(a_single_last, i_clk, i_rst_n, o_out_valid && o_frame_last && !i_out_stall, !(o_out_valid && o_frame_last))
    // thinning applies only to pixel beats that give a result
    `TSP_ASSERT_NOW(a_thin_on_pixel, i_clk, i_rst_n, ctl.thin_en, ctl.produce && !ctl.is_flush)

endmodule
